// File: hw/rtl/playfair_digraph_cipher_defines.svh
// Assertion macros for the Playfair digraph cipher RTL.
// Bodies sample on clock and are disabled while reset is high.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// Same-cycle implication.
`define PDC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PDC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pdc_pkg.sv
// Shared types, constants and helpers for the Playfair digraph cipher.
// No dependencies.
`default_nettype none

package pdc_pkg;

   localparam int DIM    = 5;
   localparam int CODE_W = 5;
   localparam int IDX_W  = 3;
   localparam int CSR_W  = 3;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [DIM-1:0][CODE_W-1:0] row_type;
   typedef row_type [DIM-1:0] square_type;

   localparam code_type LETTER_I = 5'd8;
   localparam code_type LETTER_J = 5'd9;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_SQUARE_ROW_0 = 3'd0;
   localparam logic [CSR_W-1:0] CSR_SQUARE_ROW_4 = 3'd4;

   localparam idx_type IDX_LAST = 3'(DIM - 1);

   // Fold I onto J
   function automatic code_type pdc_fold(input code_type x);
      return (x == LETTER_I) ? LETTER_J : x;
   endfunction

   // Step one position forward or backward, wrapping within the square
   function automatic idx_type pdc_step(input idx_type x, input logic back);
      idx_type res;
      if (back) begin
         res = (x == '0) ? IDX_LAST : x - 3'd1;
      end else begin
         res = (x == IDX_LAST) ? '0 : x + 3'd1;
      end
      return res;
   endfunction

   // Stage 1: folded letters and match vectors
   typedef struct packed {
      logic                 valid;
      logic                 mode;
      code_type             a;
      code_type             b;
      logic [DIM*DIM-1:0]   match_a;
      logic [DIM*DIM-1:0]   match_b;
   } s1_type;

   // Stage 2: located positions
   typedef struct packed {
      logic     valid;
      logic     mode;
      logic     hit;
      code_type a;
      code_type b;
      idx_type  ra;
      idx_type  ca;
      idx_type  rb;
      idx_type  cb;
   } s2_type;

   // Stage 3: target positions
   typedef struct packed {
      logic     valid;
      logic     hit;
      code_type a;
      code_type b;
      idx_type  ta_r;
      idx_type  ta_c;
      idx_type  tb_r;
      idx_type  tb_c;
   } s3_type;

endpackage

`default_nettype wire

// File: hw/rtl/playfair_digraph_cipher.sv
// Playfair digraph cipher: one letter pair per cycle unless stalled; 5x5 key square.
// An accepted request is registered in s1, s2, s3 and the output reg before rsp_valid.
// Stages: fold and match, locate, target positions, cell select into output reg.
// A stalled output holds every stage; no item is lost or repeated.
// Reset (synchronous) clears all stage valid bits and the key square to zero.
// Depends on pdc_pkg and playfair_digraph_cipher_defines.svh.
`default_nettype none
`include "playfair_digraph_cipher_defines.svh"

module playfair_digraph_cipher (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration write port
   input  wire logic                      csr_wr_en,
   input  wire logic [pdc_pkg::CSR_W-1:0] csr_index,
   input  wire logic [24:0]               csr_wr_data,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_mode,
   input  wire logic [4:0]                req_first_letter,
   input  wire logic [4:0]                req_second_letter,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [4:0]                     rsp_first_out,
   output logic [4:0]                     rsp_second_out,
   output logic                           rsp_located
);
   import pdc_pkg::*;

   square_type square_ff;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   s3_type     s3_ff, s3_in;
   logic       out_valid_ff;
   code_type   out_a_ff, out_a_in;
   code_type   out_b_ff, out_b_in;
   logic       out_hit_ff;
   logic       advance;
   code_type   fold_a, fold_b;
   logic       same_row, same_col;

   // Whole pipeline moves when the output register is free or being taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Key square registers
   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= '0;
      end else if (csr_wr_en && csr_index <= CSR_SQUARE_ROW_4) begin
         square_ff[csr_index] <= csr_wr_data;
      end
   end

   // Stage 1: fold I to J and compare against every cell
   always_comb begin
      fold_a = pdc_fold(req_first_letter);
      fold_b = pdc_fold(req_second_letter);
      s1_in.valid = req_valid;
      s1_in.mode  = req_mode;
      s1_in.a     = fold_a;
      s1_in.b     = fold_b;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            s1_in.match_a[r*DIM+c] = (square_ff[r][c] == fold_a);
            s1_in.match_b[r*DIM+c] = (square_ff[r][c] == fold_b);
         end
      end
   end

   // Stage 2: take the last match in row-major order
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.mode  = s1_ff.mode;
      s2_in.a     = s1_ff.a;
      s2_in.b     = s1_ff.b;
      s2_in.ra    = '0;
      s2_in.ca    = '0;
      s2_in.rb    = '0;
      s2_in.cb    = '0;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            if (s1_ff.match_a[r*DIM+c]) begin
               s2_in.ra = IDX_W'(r);
               s2_in.ca = IDX_W'(c);
            end
            if (s1_ff.match_b[r*DIM+c]) begin
               s2_in.rb = IDX_W'(r);
               s2_in.cb = IDX_W'(c);
            end
         end
      end
      s2_in.hit = (|s1_ff.match_a) && (|s1_ff.match_b);
   end

   // Stage 3: apply the row, column or rectangle rule
   always_comb begin
      same_row    = (s2_ff.ra == s2_ff.rb);
      same_col    = (s2_ff.ca == s2_ff.cb);
      s3_in.valid = s2_ff.valid;
      s3_in.hit   = s2_ff.hit;
      s3_in.a     = s2_ff.a;
      s3_in.b     = s2_ff.b;
      if (same_row) begin
         s3_in.ta_r = s2_ff.ra;
         s3_in.ta_c = pdc_step(s2_ff.ca, s2_ff.mode == MODE_DECRYPT);
         s3_in.tb_r = s2_ff.rb;
         s3_in.tb_c = pdc_step(s2_ff.cb, s2_ff.mode == MODE_DECRYPT);
      end else if (same_col) begin
         s3_in.ta_r = pdc_step(s2_ff.ra, s2_ff.mode == MODE_DECRYPT);
         s3_in.ta_c = s2_ff.ca;
         s3_in.tb_r = pdc_step(s2_ff.rb, s2_ff.mode == MODE_DECRYPT);
         s3_in.tb_c = s2_ff.cb;
      end else begin
         s3_in.ta_r = s2_ff.ra;
         s3_in.ta_c = s2_ff.cb;
         s3_in.tb_r = s2_ff.rb;
         s3_in.tb_c = s2_ff.ca;
      end
   end

   // Stage 4: read the target cells, or pass the folded letters through
   always_comb begin
      if (s3_ff.hit) begin
         out_a_in = square_ff[s3_ff.ta_r][s3_ff.ta_c];
         out_b_in = square_ff[s3_ff.tb_r][s3_ff.tb_c];
      end else begin
         out_a_in = s3_ff.a;
         out_b_in = s3_ff.b;
      end
   end

   // Valid bits clear on reset; payload holds on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_ff.valid  <= s1_in.valid;
         s2_ff.valid  <= s2_in.valid;
         s3_ff.valid  <= s3_in.valid;
         out_valid_ff <= s3_ff.valid;
      end
      if (advance) begin
         s1_ff.mode    <= s1_in.mode;
         s1_ff.a       <= s1_in.a;
         s1_ff.b       <= s1_in.b;
         s1_ff.match_a <= s1_in.match_a;
         s1_ff.match_b <= s1_in.match_b;
         s2_ff.mode    <= s2_in.mode;
         s2_ff.hit     <= s2_in.hit;
         s2_ff.a       <= s2_in.a;
         s2_ff.b       <= s2_in.b;
         s2_ff.ra      <= s2_in.ra;
         s2_ff.ca      <= s2_in.ca;
         s2_ff.rb      <= s2_in.rb;
         s2_ff.cb      <= s2_in.cb;
         s3_ff.hit     <= s3_in.hit;
         s3_ff.a       <= s3_in.a;
         s3_ff.b       <= s3_in.b;
         s3_ff.ta_r    <= s3_in.ta_r;
         s3_ff.ta_c    <= s3_in.ta_c;
         s3_ff.tb_r    <= s3_in.tb_r;
         s3_ff.tb_c    <= s3_in.tb_c;
         out_a_ff      <= out_a_in;
         out_b_ff      <= out_b_in;
         out_hit_ff    <= s3_ff.hit;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_first_out  = out_a_ff;
   assign rsp_second_out = out_b_ff;
   assign rsp_located    = out_hit_ff;

   `PDC_ASSERT_IMP(a_stall_blocks_entry, rsp_valid && !rsp_ready, !req_ready,
      "request taken while output stalled")
   `PDC_ASSERT_NXT(a_entry_reaches_s1, req_valid && req_ready, s1_ff.valid,
      "accepted item missing from stage 1")
   `PDC_ASSERT_IMP(a_passthrough_folded, rsp_valid && !rsp_located,
      rsp_first_out != LETTER_I && rsp_second_out != LETTER_I,
      "passthrough letter not folded")
   `PDC_ASSERT_IMP(a_target_in_square, s3_ff.valid && s3_ff.hit,
      s3_ff.ta_r <= IDX_LAST && s3_ff.ta_c <= IDX_LAST &&
      s3_ff.tb_r <= IDX_LAST && s3_ff.tb_c <= IDX_LAST,
      "target position outside square")

endmodule

`default_nettype wire

// File: tb/sv/tb_playfair_digraph_cipher.sv
// Self-checking testbench for the Playfair digraph cipher block.
// It drives random and directed letter pairs against several key squares and compares
// each result with an in-bench prediction. Depends on pdc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;
   import pdc_pkg::*;

   localparam int IDLE_PCT    = 37;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 10;
   localparam int REPORT_MAX  = 10;
   localparam logic [CSR_W-1:0] CSR_PAST_LAST = CSR_SQUARE_ROW_4 + 1'b1;
   localparam logic [CSR_W-1:0] CSR_TOP       = '1;
   localparam code_type CODE_MAX = '1;

   typedef struct packed {
      logic     mode;
      code_type first_letter;
      code_type second_letter;
   } letter_pair_type;

   typedef struct packed {
      code_type first_out;
      code_type second_out;
      logic     located;
   } cipher_pair_type;

   typedef enum {SQ_ZERO, SQ_ALPHABET, SQ_SHUFFLED, SQ_DUPLICATES, SQ_NOISE, SQ_ONES}
      square_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_index = '0;
   logic [24:0] csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_mode = MODE_ENCRYPT;
   logic [4:0] req_first_letter = '0;
   logic [4:0] req_second_letter = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_first_out;
   logic [4:0] rsp_second_out;
   logic       rsp_located;

   // Testbench copy of the key square and the words that load it
   code_type    key_cell [DIM][DIM];
   logic [24:0] square_word [DIM];

   letter_pair_type pending_pairs [$];
   cipher_pair_type expected_pairs [$];
   int  mismatch_count = 0;
   int  stall_cycles = 0;
   bit  steady_run = 1'b0;

   playfair_digraph_cipher dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_first_letter  (req_first_letter),
      .req_second_letter (req_second_letter),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_first_out     (rsp_first_out),
      .rsp_second_out    (rsp_second_out),
      .rsp_located       (rsp_located)
   );

   always #5 clock = ~clock;

   // Predict one pair: fold I to J, take the last match in row-major order, apply the rule
   function automatic cipher_pair_type encipher_pair(letter_pair_type p);
      code_type        a;
      code_type        b;
      int              ra = 0;
      int              ca = 0;
      int              rb = 0;
      int              cb = 0;
      int              shift;
      bit              found_a = 1'b0;
      bit              found_b = 1'b0;
      cipher_pair_type res;
      a = (p.first_letter == LETTER_I) ? LETTER_J : p.first_letter;
      b = (p.second_letter == LETTER_I) ? LETTER_J : p.second_letter;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            if (key_cell[r][c] == a) begin
               ra = r;
               ca = c;
               found_a = 1'b1;
            end
            if (key_cell[r][c] == b) begin
               rb = r;
               cb = c;
               found_b = 1'b1;
            end
         end
      end
      shift = (p.mode == MODE_DECRYPT) ? DIM - 1 : 1;
      res.located = found_a && found_b;
      if (!res.located) begin
         res.first_out  = a;
         res.second_out = b;
      end else if (ra == rb) begin
         res.first_out  = key_cell[ra][(ca + shift) % DIM];
         res.second_out = key_cell[rb][(cb + shift) % DIM];
      end else if (ca == cb) begin
         res.first_out  = key_cell[(ra + shift) % DIM][ca];
         res.second_out = key_cell[(rb + shift) % DIM][cb];
      end else begin
         res.first_out  = key_cell[ra][cb];
         res.second_out = key_cell[rb][ca];
      end
      return res;
   endfunction

   // Drive request items from the pending queue, holding each until accepted
   always @(posedge clock) begin : drive_req
      letter_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_pairs.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
            next_pair = pending_pairs.pop_front();
            req_valid         <= 1'b1;
            req_mode          <= next_pair.mode;
            req_first_letter  <= next_pair.first_letter;
            req_second_letter <= next_pair.second_letter;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         end
      end
   endtask

   // Predict accepted items and check accepted results in order
   always @(posedge clock) begin : watch_ports
      letter_pair_type seen_pair;
      cipher_pair_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_pair.mode          = req_mode;
            seen_pair.first_letter  = req_first_letter;
            seen_pair.second_letter = req_second_letter;
            expected_pairs = {expected_pairs, encipher_pair(seen_pair)};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("unexpected item: %0d %0d located %0d",
                           rsp_first_out, rsp_second_out, rsp_located);
               end
            end else begin
               want = expected_pairs.pop_front();
               check_field("first_out", int'(want.first_out), int'(rsp_first_out));
               check_field("second_out", int'(want.second_out), int'(rsp_second_out));
               check_field("located", int'(want.located), int'(rsp_located));
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_playfair_digraph_cipher: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic add_pair(input logic mode, input int a, input int b);
      letter_pair_type p;
      p.mode          = mode;
      p.first_letter  = code_type'(a);
      p.second_letter = code_type'(b);
      pending_pairs = {pending_pairs, p};
   endtask

   // Fill square_word with a layout of the given kind
   task automatic build_square(input square_kind_type kind);
      code_type layout [DIM*DIM];
      code_type tmp;
      int       n = 0;
      int       j;
      for (int k = 0; k < 26; k++) begin
         if (code_type'(k) != LETTER_I) begin
            layout[n] = code_type'(k);
            n++;
         end
      end
      if (kind == SQ_SHUFFLED || kind == SQ_DUPLICATES) begin
         for (int k = DIM*DIM - 1; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = layout[k];
            layout[k] = layout[j];
            layout[j] = tmp;
         end
      end
      // Plant repeated letters, cells holding I and codes past Z
      if (kind == SQ_DUPLICATES) begin
         repeat ($urandom_range(8, 3)) begin
            j = $urandom_range(DIM*DIM - 1);
            case ($urandom_range(2))
               0: layout[j] = layout[$urandom_range(DIM*DIM - 1)];
               1: layout[j] = LETTER_I;
               default: layout[j] = code_type'($urandom_range(31, 26));
            endcase
         end
      end
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            square_word[r][CODE_W*c +: CODE_W] = layout[r*DIM + c];
         end
         case (kind)
            SQ_ZERO:  square_word[r] = '0;
            SQ_ONES:  square_word[r] = '1;
            SQ_NOISE: square_word[r] = 25'($urandom());
            default: ;
         endcase
      end
   endtask

   // Write all five rows, mirroring each into key_cell, plus one stray index
   task automatic load_square();
      for (int r = 0; r < DIM; r++) begin
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_SQUARE_ROW_0 + CSR_W'(r);
         csr_wr_data <= square_word[r];
         for (int c = 0; c < DIM; c++) begin
            key_cell[r][c] = square_word[r][CODE_W*c +: CODE_W];
         end
      end
      // Out-of-range index: must be dropped
      @(posedge clock);
      csr_index   <= CSR_W'($urandom_range(CSR_TOP, CSR_PAST_LAST));
      csr_wr_data <= 25'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_pairs.size() != 0 || req_valid || expected_pairs.size() != 0);
   endtask

   // Mostly pairs taken from the square in row, column, rectangle or same-cell shapes
   task automatic add_random_pairs(input int count);
      letter_pair_type p;
      int              pick;
      int              ra;
      int              ca;
      int              rb;
      int              cb;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         ra = $urandom_range(DIM - 1);
         ca = $urandom_range(DIM - 1);
         rb = $urandom_range(DIM - 1);
         cb = $urandom_range(DIM - 1);
         case ($urandom_range(3))
            0: rb = ra;
            1: cb = ca;
            2: ;
            default: begin
               rb = ra;
               cb = ca;
            end
         endcase
         p.mode          = 1'($urandom_range(1));
         p.first_letter  = key_cell[ra][ca];
         p.second_letter = key_cell[rb][cb];
         if (pick >= 75) begin
            p.first_letter  = code_type'($urandom_range(CODE_MAX));
            p.second_letter = code_type'($urandom_range(CODE_MAX));
         end else if (pick >= 60) begin
            p.second_letter = code_type'($urandom_range(CODE_MAX));
         end
         // Present J as I now and then to exercise the fold
         if (p.first_letter == LETTER_J && $urandom_range(1)) p.first_letter = LETTER_I;
         if (p.second_letter == LETTER_J && $urandom_range(1)) p.second_letter = LETTER_I;
         pending_pairs = {pending_pairs, p};
      end
   endtask

   task automatic run_phase(input square_kind_type kind, input int count, input bit steady);
      build_square(kind);
      load_square();
      steady_run = steady;
      add_random_pairs(count);
      wait_drained();
      steady_run = 1'b0;
   endtask

   initial begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            key_cell[r][c] = '0;
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Square after reset: every cell is A
      add_pair(MODE_ENCRYPT, 0, 0);
      add_pair(MODE_DECRYPT, 0, 5);
      add_pair(MODE_ENCRYPT, 31, int'(LETTER_I));
      wait_drained();

      // Plain alphabet square: rows, wraps, rectangles, fold, missing letters
      build_square(SQ_ALPHABET);
      load_square();
      for (int m = 0; m < 2; m++) begin
         add_pair(1'(m), 0, 1);
         add_pair(1'(m), 4, 0);
         add_pair(1'(m), 0, 21);
         add_pair(1'(m), 0, 25);
         add_pair(1'(m), 25, 25);
         add_pair(1'(m), int'(LETTER_I), int'(LETTER_J));
         add_pair(1'(m), int'(LETTER_I), 0);
         add_pair(1'(m), 26, 0);
         add_pair(1'(m), 31, 31);
         add_pair(1'(m), 0, 31);
         add_pair(1'(m), 12, 17);
      end
      wait_drained();

      // Random phases over several squares, extremes among them
      run_phase(SQ_SHUFFLED, 300, 1'b1);
      run_phase(SQ_SHUFFLED, 400, 1'b0);
      run_phase(SQ_DUPLICATES, 300, 1'b0);
      run_phase(SQ_NOISE, 200, 1'b0);
      run_phase(SQ_ONES, 100, 1'b0);
      run_phase(SQ_ZERO, 100, 1'b0);
      run_phase(SQ_SHUFFLED, 450, 1'b0);

      // Let any stray result show up before deciding
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_pairs.size() == 0) begin
         $display("tb_playfair_digraph_cipher: PASS");
      end else begin
         $display("tb_playfair_digraph_cipher: FAIL");
      end
      $finish;
   end

endmodule
